// ===== hw/rtl/rusce_pkg.sv =====
// Shared types and constants of the reliable datagram connection engine.
package rusce_pkg;

   localparam logic [1:0] FUNC_HEADER = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_CLOSE  = 2'd2;
   localparam logic [1:0] FUNC_WRITE  = 2'd3;

   localparam int unsigned IDLE_W = 20;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 20'd100000;
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   typedef enum logic [2:0] {
      OP_CONNECT,
      OP_ACK,
      OP_DATA,
      OP_TICK,
      OP_CLOSE,
      OP_WRITE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0]       conn_id;
      logic [31:0]       addr;
      logic [15:0]       port;
      logic [31:0]       expected;
      logic [31:0]       next_send;
      logic [IDLE_W-1:0] idle;
      logic              heard;
   } entry_type;

endpackage

// ===== hw/rtl/reliable_udp_server_connection_engine.sv =====
// Top level of the reliable datagram connection engine.
//
// req_ channel carries one word per event: a received packet header, an epoch
// tick, a close or a write request (selector in req_tuser). rsp_ channel
// returns zero or more result words per event, rsp_tlast on the final one.
// csr_wr_en/csr_wr_data set the idle epoch limit; the user must write it only
// while the block is idle, which the block itself does not enforce. The
// connection table sits in one synchronous memory of MAX_CONNS entries; the
// sequencer reads one entry, checks it in the following cycle, and writes
// back. A tick skips a free entry without checking it. A result word is
// formed when its entry is checked (for a connect or a refused write, in the
// finish state) and registered onto rsp_. A lookup stops at the first match.
// A new request is taken only after the previous one has finished.
// Reset clears the valid bits, the id counter and the output valid flag; the
// entry memory needs no clearing. When the receiver holds rsp_tready low on a
// pending word, the sequencer waits with its next one and the table stays untouched.
module reliable_udp_server_connection_engine #(
   parameter int MAX_CONNS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] conn_id, [63:32] seq, [64] payload_is_nil, [96:65] src_addr,
   // [112:97] src_port, [119:113] zero
   input  logic [119:0] req_tdata,
   // [1:0] func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] out_conn_id, [63:32] out_seq, [95:64] dest_addr, [111:96] dest_port
   output logic [111:0] rsp_tdata,
   // [0] send_ack, [1] deliver_data, [2] release_entry, [3] evicted,
   // [4] write_refused
   output logic [4:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [19:0]  csr_wr_data
);

   localparam int IW = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CONNS - 1);

   rusce_pkg::entry_type mem [MAX_CONNS];
   rusce_pkg::entry_type rd_q_ff;

   rusce_pkg::state_type state_ff, state_in;
   rusce_pkg::op_type    op_ff, op_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [31:0]          id_ff, id_in;
   logic [MAX_CONNS-1:0] valid_ff, valid_in;
   logic [19:0]          limit_ff;

   logic [31:0] cid_ff, seq_ff, addr_ff;
   logic [15:0] port_ff;

   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [111:0] rsp_tdata_ff, rsp_tdata_in;
   logic [4:0]   rsp_tuser_ff, rsp_tuser_in;
   logic         rsp_tlast_ff, rsp_tlast_in;

   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   rusce_pkg::entry_type mem_wd;

   logic                 out_free, is_last, cur_valid, higher_valid;
   logic [19:0]          new_idle;
   logic                 evict;
   logic                 accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == rusce_pkg::ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign is_last    = (idx_ff == LAST_IDX);
   assign cur_valid  = valid_ff[idx_ff];

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_comb begin
      higher_valid = 1'b0;
      for (int j = 0; j < MAX_CONNS; j++) begin
         if (j > int'(idx_ff) && valid_ff[j]) begin
            higher_valid = 1'b1;
         end
      end
   end

   always_comb begin
      new_idle = rd_q_ff.idle;
      if (rd_q_ff.heard) begin
         new_idle = '0;
      end else if (rd_q_ff.idle != rusce_pkg::IDLE_MAX) begin
         new_idle = rd_q_ff.idle + 20'd1;
      end
      evict = (new_idle > limit_ff);
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      id_in         = id_ff;
      valid_in      = valid_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = rd_q_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         rusce_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = rusce_pkg::ST_READ;
               case (req_tuser)
                  rusce_pkg::FUNC_HEADER: begin
                     if (req_tdata[31:0] == 32'd0) begin
                        op_in = rusce_pkg::OP_CONNECT;
                        if (req_tdata[63:32] != 32'd0 || !req_tdata[64]) begin
                           state_in = rusce_pkg::ST_IDLE;
                        end
                     end else if (req_tdata[64]) begin
                        op_in = rusce_pkg::OP_ACK;
                     end else begin
                        op_in = rusce_pkg::OP_DATA;
                     end
                  end
                  rusce_pkg::FUNC_TICK:  op_in = rusce_pkg::OP_TICK;
                  rusce_pkg::FUNC_CLOSE: op_in = rusce_pkg::OP_CLOSE;
                  default:               op_in = rusce_pkg::OP_WRITE;
               endcase
            end
         end
         rusce_pkg::ST_READ: begin
            if (op_ff == rusce_pkg::OP_TICK && !cur_valid) begin
               if (is_last) begin
                  state_in = rusce_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end else begin
               state_in = rusce_pkg::ST_CHECK;
            end
         end
         rusce_pkg::ST_CHECK: begin
            case (op_ff)
               rusce_pkg::OP_CONNECT: begin
                  if (cur_valid && rd_q_ff.addr == addr_ff && rd_q_ff.port == port_ff) begin
                     state_in = rusce_pkg::ST_IDLE;
                  end else begin
                     if (!cur_valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = idx_ff;
                     end
                     if (is_last) begin
                        state_in = rusce_pkg::ST_FINISH;
                     end else begin
                        idx_in   = idx_ff + IW'(1);
                        state_in = rusce_pkg::ST_READ;
                     end
                  end
               end
               rusce_pkg::OP_TICK: begin
                  if (out_free) begin
                     mem_we        = 1'b1;
                     mem_wd.idle   = new_idle;
                     mem_wd.heard  = 1'b0;
                     if (evict) begin
                        valid_in[idx_ff] = 1'b0;
                     end
                     rsp_tvalid_in = 1'b1;
                     rsp_tdata_in  = {rd_q_ff.port, rd_q_ff.addr,
                                      rd_q_ff.expected - 32'd1, rd_q_ff.conn_id};
                     rsp_tuser_in  = {1'b0, evict, 2'b00, 1'b1};
                     rsp_tlast_in  = !higher_valid;
                     if (is_last || !higher_valid) begin
                        state_in = rusce_pkg::ST_IDLE;
                     end else begin
                        idx_in   = idx_ff + IW'(1);
                        state_in = rusce_pkg::ST_READ;
                     end
                  end
               end
               default: begin
                  if (cur_valid && rd_q_ff.conn_id == cid_ff) begin
                     case (op_ff)
                        rusce_pkg::OP_ACK: begin
                           if (out_free) begin
                              mem_we        = 1'b1;
                              mem_wd.heard  = 1'b1;
                              rsp_tvalid_in = 1'b1;
                              rsp_tdata_in  = {48'd0, seq_ff, cid_ff};
                              rsp_tuser_in  = 5'b00100;
                              rsp_tlast_in  = 1'b1;
                              state_in      = rusce_pkg::ST_IDLE;
                           end
                        end
                        rusce_pkg::OP_DATA: begin
                           if (rd_q_ff.expected != seq_ff) begin
                              state_in = rusce_pkg::ST_IDLE;
                           end else if (out_free) begin
                              mem_we          = 1'b1;
                              mem_wd.expected = rd_q_ff.expected + 32'd1;
                              mem_wd.heard    = 1'b1;
                              rsp_tvalid_in   = 1'b1;
                              rsp_tdata_in    = {rd_q_ff.port, rd_q_ff.addr, seq_ff, cid_ff};
                              rsp_tuser_in    = 5'b00011;
                              rsp_tlast_in    = 1'b1;
                              state_in        = rusce_pkg::ST_IDLE;
                           end
                        end
                        rusce_pkg::OP_CLOSE: begin
                           valid_in[idx_ff] = 1'b0;
                           state_in         = rusce_pkg::ST_IDLE;
                        end
                        default: begin
                           if (out_free) begin
                              mem_we           = 1'b1;
                              mem_wd.next_send = rd_q_ff.next_send + 32'd1;
                              rsp_tvalid_in    = 1'b1;
                              rsp_tdata_in     = {48'd0, rd_q_ff.next_send, cid_ff};
                              rsp_tuser_in     = 5'b00000;
                              rsp_tlast_in     = 1'b1;
                              state_in         = rusce_pkg::ST_IDLE;
                           end
                        end
                     endcase
                  end else if (is_last) begin
                     state_in = (op_ff == rusce_pkg::OP_WRITE) ? rusce_pkg::ST_FINISH
                                                               : rusce_pkg::ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     state_in = rusce_pkg::ST_READ;
                  end
               end
            endcase
         end
         rusce_pkg::ST_FINISH: begin
            if (op_ff == rusce_pkg::OP_WRITE) begin
               if (out_free) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = {80'd0, cid_ff};
                  rsp_tuser_in  = 5'b10000;
                  rsp_tlast_in  = 1'b1;
                  state_in      = rusce_pkg::ST_IDLE;
               end
            end else if (!free_found_ff) begin
               state_in = rusce_pkg::ST_IDLE;
            end else if (out_free) begin
               id_in                 = id_ff + 32'd1;
               mem_we                = 1'b1;
               mem_wa                = free_idx_ff;
               mem_wd.conn_id        = id_ff + 32'd1;
               mem_wd.addr           = addr_ff;
               mem_wd.port           = port_ff;
               mem_wd.expected       = 32'd1;
               mem_wd.next_send      = 32'd1;
               mem_wd.idle           = '0;
               mem_wd.heard          = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               rsp_tvalid_in         = 1'b1;
               rsp_tdata_in          = {port_ff, addr_ff, 32'd0, id_ff + 32'd1};
               rsp_tuser_in          = 5'b00001;
               rsp_tlast_in          = 1'b1;
               state_in              = rusce_pkg::ST_IDLE;
            end
         end
         default: state_in = rusce_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rusce_pkg::ST_IDLE;
         valid_ff      <= '0;
         id_ff         <= '0;
         limit_ff      <= rusce_pkg::IDLE_LIMIT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         id_ff         <= id_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      free_idx_ff   <= free_idx_in;
      free_found_ff <= free_found_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tlast_ff  <= rsp_tlast_in;
      if (accept) begin
         cid_ff  <= req_tdata[31:0];
         seq_ff  <= req_tdata[63:32];
         addr_ff <= req_tdata[96:65];
         port_ff <= req_tdata[112:97];
      end
   end

endmodule

// ===== sim/reliable_udp_server_connection_engine_tb.sv =====
// Self-checking testbench of the connection engine: directed table, random traffic.
`timescale 1ns / 100ps

module reliable_udp_server_connection_engine_tb;

   localparam int NCONN = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [111:0] data;
      logic [4:0]   user;
      logic         last;
   } rsp_word_type;

   typedef struct {
      logic [1:0]   func;
      logic [31:0]  cid;
      logic [31:0]  seq;
      logic         nil;
      logic [31:0]  addr;
      logic [15:0]  port;
      bit           has_exp;
      rsp_word_type exp_word;
   } req_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [4:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [19:0]  csr_wr_data = '0;

   // shadow connection table
   bit          tbl_valid [NCONN];
   logic [31:0] tbl_cid   [NCONN];
   logic [31:0] tbl_addr  [NCONN];
   logic [15:0] tbl_port  [NCONN];
   logic [31:0] tbl_rx    [NCONN];
   logic [31:0] tbl_tx    [NCONN];
   logic [19:0] tbl_idle  [NCONN];
   bit          tbl_heard [NCONN];
   logic [31:0] id_ctr;
   logic [19:0] idle_limit;

   rsp_word_type rsp_expect_q[$];
   int           errors = 0;
   int           cycles = 0;
   bit           hold_req = 0;
   logic [31:0]  peer_addr [24];
   logic [15:0]  peer_port [24];
   req_row_type  dir_rows[$];

   reliable_udp_server_connection_engine #(.MAX_CONNS(NCONN)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic rsp_word_type make_word(bit ack, logic [31:0] cid, logic [31:0] sq,
                                              logic [31:0] addr, logic [15:0] port,
                                              bit dlv, bit rel, bit ev, bit refused);
      rsp_word_type w;
      w.data = {ack ? port : 16'd0, ack ? addr : 32'd0, sq, cid};
      w.user = {refused, ev, rel, dlv, ack};
      w.last = 1'b0;
      return w;
   endfunction

   function automatic void queue_expected(rsp_word_type w);
      rsp_expect_q = {rsp_expect_q, w};
   endfunction

   function automatic void add_row(req_row_type r);
      dir_rows = {dir_rows, r};
   endfunction

   function automatic int lookup_id(logic [31:0] cid);
      for (int i = 0; i < NCONN; i++)
         if (tbl_valid[i] && tbl_cid[i] == cid) return i;
      return -1;
   endfunction

   // update the shadow table for one accepted request, queue the words it causes
   task automatic conn_table_step(logic [1:0] func, logic [31:0] cid, logic [31:0] sq,
                                  logic nil, logic [31:0] addr, logic [15:0] port);
      int n0;
      int e;
      int fr;
      bit ev;
      n0 = rsp_expect_q.size();
      case (func)
         rusce_pkg::FUNC_HEADER: begin
            if (cid == 0 && sq == 0 && nil) begin
               e = -1;
               fr = -1;
               for (int i = 0; i < NCONN; i++)
                  if (tbl_valid[i] && tbl_addr[i] == addr && tbl_port[i] == port && e < 0)
                     e = i;
               for (int i = 0; i < NCONN; i++)
                  if (!tbl_valid[i] && fr < 0) fr = i;
               if (e < 0 && fr >= 0) begin
                  id_ctr = id_ctr + 32'd1;
                  tbl_valid[fr] = 1; tbl_cid[fr] = id_ctr;
                  tbl_addr[fr] = addr; tbl_port[fr] = port;
                  tbl_rx[fr] = 1; tbl_tx[fr] = 1; tbl_idle[fr] = 0; tbl_heard[fr] = 1;
                  queue_expected(make_word(1, id_ctr, 0, addr, port, 0, 0, 0, 0));
               end
            end else if (cid != 0) begin
               e = lookup_id(cid);
               if (e >= 0 && nil) begin
                  tbl_heard[e] = 1;
                  queue_expected(make_word(0, cid, sq, 0, 0, 0, 1, 0, 0));
               end else if (e >= 0 && tbl_rx[e] == sq) begin
                  tbl_rx[e] = tbl_rx[e] + 32'd1;
                  tbl_heard[e] = 1;
                  queue_expected(make_word(1, cid, sq, tbl_addr[e], tbl_port[e],
                                           1, 0, 0, 0));
               end
            end
         end
         rusce_pkg::FUNC_TICK: begin
            for (int i = 0; i < NCONN; i++) begin
               if (tbl_valid[i]) begin
                  ev = 0;
                  if (tbl_heard[i]) begin
                     tbl_idle[i] = 0;
                     tbl_heard[i] = 0;
                  end else if (tbl_idle[i] != rusce_pkg::IDLE_MAX) begin
                     tbl_idle[i] = tbl_idle[i] + 20'd1;
                  end
                  if (tbl_idle[i] > idle_limit) begin
                     ev = 1;
                     tbl_valid[i] = 0;
                  end
                  queue_expected(make_word(1, tbl_cid[i], tbl_rx[i] - 32'd1, tbl_addr[i],
                                           tbl_port[i], 0, 0, ev, 0));
               end
            end
         end
         rusce_pkg::FUNC_CLOSE: begin
            e = lookup_id(cid);
            if (e >= 0) tbl_valid[e] = 0;
         end
         default: begin
            e = lookup_id(cid);
            if (e >= 0) begin
               queue_expected(make_word(0, cid, tbl_tx[e], 0, 0, 0, 0, 0, 0));
               tbl_tx[e] = tbl_tx[e] + 32'd1;
            end else begin
               queue_expected(make_word(0, cid, 0, 0, 0, 0, 0, 0, 1));
            end
         end
      endcase
      if (rsp_expect_q.size() > n0) rsp_expect_q[$].last = 1'b1;
   endtask

   task automatic send_word(req_row_type r);
      int gap;
      int n0;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, r.port, r.addr, r.nil, r.seq, r.cid};
      req_tuser  <= r.func;
      do @(posedge clock); while (!req_tready);
      n0 = rsp_expect_q.size();
      conn_table_step(r.func, r.cid, r.seq, r.nil, r.addr, r.port);
      if (r.has_exp && rsp_expect_q.size() == n0 + 1) rsp_expect_q[n0] = r.exp_word;
      else if (r.has_exp) begin
         $display("%0t: directed row expected one word, predictor gave %0d", $time,
                  rsp_expect_q.size() - n0);
         errors++;
      end
   endtask

   function automatic req_row_type row(logic [1:0] func, logic [31:0] cid, logic [31:0] sq,
                                       logic nil, logic [31:0] addr, logic [15:0] port);
      req_row_type r;
      r.func = func; r.cid = cid; r.seq = sq; r.nil = nil; r.addr = addr; r.port = port;
      r.has_exp = 0;
      r.exp_word = make_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
      return r;
   endfunction

   function automatic req_row_type row_exp(req_row_type r, rsp_word_type w);
      r.has_exp = 1;
      w.last = 1'b1;
      r.exp_word = w;
      return r;
   endfunction

   function automatic logic [31:0] pick_cid(int live_pct);
      int i;
      i = $urandom_range(0, NCONN - 1);
      if ($urandom_range(0, 99) < live_pct && tbl_valid[i]) return tbl_cid[i];
      if ($urandom_range(0, 1)) return $urandom_range(1, 40);
      return $urandom;
   endfunction

   function automatic req_row_type random_row();
      req_row_type r;
      int k;
      int p;
      int i;
      r = row(rusce_pkg::FUNC_HEADER, 0, 0, 1, $urandom, 16'($urandom));
      k = $urandom_range(0, 99);
      p = $urandom_range(0, 23);
      if (k < 18) begin
         r.addr = peer_addr[p]; r.port = peer_port[p];
      end else if (k < 33) begin
         r.cid = pick_cid(80); r.seq = $urandom;
      end else if (k < 55) begin
         i = $urandom_range(0, NCONN - 1);
         r.nil = 0;
         r.cid = tbl_valid[i] ? tbl_cid[i] : pick_cid(80);
         r.seq = (tbl_valid[i] && $urandom_range(0, 4) != 0) ? tbl_rx[i] : $urandom;
      end else if (k < 60) begin
         r.seq = $urandom; r.nil = 1'($urandom_range(0, 1));
      end else if (k < 70) begin
         r.func = rusce_pkg::FUNC_TICK;
      end else if (k < 76) begin
         r.func = rusce_pkg::FUNC_CLOSE; r.cid = pick_cid(75);
      end else begin
         r.func = rusce_pkg::FUNC_WRITE; r.cid = pick_cid(70);
      end
      return r;
   endfunction

   task automatic set_idle_limit(logic [19:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      idle_limit = v;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result receiver
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expect_q.size() == 0) begin
            $display("%0t: unexpected word data=%h user=%h last=%b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            w = rsp_expect_q.pop_front();
            if (rsp_tdata !== w.data || rsp_tuser !== w.user || rsp_tlast !== w.last) begin
               $display("%0t: mismatch expected data=%h user=%h last=%b actual data=%h user=%h last=%b",
                        $time, w.data, w.user, w.last, rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [19:0] limits [4];
      for (int i = 0; i < NCONN; i++) tbl_valid[i] = 0;
      id_ctr = 0;
      idle_limit = rusce_pkg::IDLE_LIMIT_RESET;
      for (int i = 0; i < 24; i++) begin
         peer_addr[i] = $urandom;
         peer_port[i] = 16'($urandom);
      end
      limits[0] = 20'd0;
      limits[1] = 20'hFFFFF;
      limits[2] = 20'd3;
      limits[3] = 20'($urandom_range(1, 8));

      add_row(row_exp(row(rusce_pkg::FUNC_WRITE, 5, 0, 0, 0, 0),
                      make_word(0, 5, 0, 0, 0, 0, 0, 0, 1)));
      add_row(row(rusce_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      add_row(row_exp(row(rusce_pkg::FUNC_HEADER, 0, 0, 1, 32'hFFFFFFFF, 16'hFFFF),
                      make_word(1, 1, 0, 32'hFFFFFFFF, 16'hFFFF, 0, 0, 0, 0)));
      add_row(row(rusce_pkg::FUNC_HEADER, 0, 0, 1, 32'hFFFFFFFF, 16'hFFFF));
      add_row(row_exp(row(rusce_pkg::FUNC_HEADER, 0, 0, 1, 0, 0),
                      make_word(1, 2, 0, 0, 0, 0, 0, 0, 0)));
      add_row(row(rusce_pkg::FUNC_HEADER, 0, 5, 1, 1, 1));
      add_row(row(rusce_pkg::FUNC_HEADER, 0, 0, 0, 1, 1));
      add_row(row(rusce_pkg::FUNC_HEADER, 1, 1, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_HEADER, 1, 1, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_HEADER, 2, 32'hFFFFFFFF, 0, 0, 0));
      add_row(row_exp(row(rusce_pkg::FUNC_HEADER, 1, 32'hFFFFFFFF, 1, 0, 0),
                      make_word(0, 1, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0)));
      add_row(row(rusce_pkg::FUNC_HEADER, 99, 0, 1, 0, 0));
      add_row(row(rusce_pkg::FUNC_HEADER, 32'hFFFFFFFF, 1, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_WRITE, 1, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_WRITE, 1, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_WRITE, 2, 0, 0, 0, 0));
      add_row(row_exp(row(rusce_pkg::FUNC_WRITE, 32'hFFFFFFFF, 0, 0, 0, 0),
                      make_word(0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 1)));
      add_row(row(rusce_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_CLOSE, 2, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_CLOSE, 77, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_HEADER, 2, 1, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_WRITE, 2, 0, 0, 0, 0));
      add_row(row(rusce_pkg::FUNC_HEADER, 0, 0, 1, 32'h12345678, 16'h8001));
      add_row(row(rusce_pkg::FUNC_TICK, 0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_word(dir_rows[i]);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         set_idle_limit(limits[ph]);
         // fill the table early so the full-table refusal gets exercised
         for (int i = 0; i < 18; i++)
            send_word(row(rusce_pkg::FUNC_HEADER, 0, 0, 1, peer_addr[i], peer_port[i]));
         for (int n = 0; n < 32; n++) begin
            if (ph == 1 && n == 10) hold_req = 1;
            if (ph == 2 && n == 20) begin
               req_tvalid <= 1'b0;
               while (rsp_expect_q.size() != 0) @(posedge clock);
            end
            send_word(random_row());
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
